FILE: rtl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH   = 8;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAT_W  = 2;
    localparam int OUT_W   = ((VAL_W + CNT_W + 7) / 8) * 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    gt;
        logic signed [VAL_W-1:0] value;
    } t_link;

    // command broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

endpackage

FILE: rtl/sorted_priority_queue.sv
// Sorted min-priority queue built as a row of compare-and-shift cells.
// Throughput: one item per cycle unless the output stalls; every cell compares
// against the broadcast value and shifts in the same cycle, so insert and remove
// both finish at once, and the result is registered into the output register.
// Reset (synchronous, active low) empties the queue and the output register;
// stored values are not cleared.
module sorted_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [0:0]  i_s_tuser,   // [0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [spq_pkg::OUT_W-1:0] o_m_tdata,  // [31:0] removed_value, [35:32] count
    output logic [1:0]  o_m_tuser    // [1:0] status
);
    import spq_pkg::*;

    logic                    accept;
    logic                    is_rem;
    logic                    full;
    logic                    empty;
    t_cmd                    cmd;
    t_link                   links [DEPTH];
    t_link                   left_in [DEPTH];
    t_link                   right_in [DEPTH];
    logic [DEPTH-1:0]        valid_vec;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_status;
    logic [STAT_W-1:0]       n_status;
    logic signed [VAL_W-1:0] r_removed;
    logic signed [VAL_W-1:0] n_removed;
    logic [CNT_W-1:0]        r_out_count;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_rem     = (i_s_tuser[0] == OP_REMOVE);
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);

    assign cmd.ins   = accept && !is_rem && !full;
    assign cmd.rem   = accept && is_rem && !empty;
    assign cmd.value = i_s_tdata;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left_in[g] = '{valid: 1'b1, gt: 1'b0, value: '0};
            end else begin : g_mid
                assign left_in[g] = links[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_in[g] = '{valid: 1'b0, gt: 1'b1, value: '0};
            end else begin : g_inner
                assign right_in[g] = links[g+1];
            end
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_left  (left_in[g]),
                .i_right (right_in[g]),
                .o_link  (links[g])
            );
            assign valid_vec[g] = links[g].valid;
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_status  = ST_DONE;
        n_removed = '0;
        if (is_rem) begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count   = r_count - CNT_W'(1);
                n_removed = links[0].value;
            end
        end else begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status    <= n_status;
            r_removed   <= n_removed;
            r_out_count <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = OUT_W'({r_out_count, r_removed});

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_valid_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (links[0].valid && links[1].valid) |-> (links[0].value <= links[1].value))
        else $error("head cells out of order");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_DONE) |-> (r_removed == '0))
        else $error("rejected item carries a removed value");
`endif

endmodule

FILE: rtl/spq_cell.sv
module spq_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_cmd i_cmd,
    input  spq_pkg::t_link i_left,
    input  spq_pkg::t_link i_right,
    output spq_pkg::t_link o_link
);
    import spq_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;
    logic                    gt;

    // empty cells count as larger than anything
    assign gt = !r_valid || (r_value > i_cmd.value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_cmd.ins) begin
            n_valid = r_valid || i_left.valid;
            if (i_left.gt) begin
                n_value = i_left.value;
            end else if (gt) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.rem) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_link = '{valid: r_valid, gt: gt, value: r_value};

endmodule
